FILE: rtl/hpum_pkg.sv
// ----------------------------------------------------------------------------
// hpum_pkg: shared definitions for the heap page usage map
// Item kinds, class codes, page record layout, controller states and the
// command and status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package hpum_pkg;

  // Item kinds
  localparam logic [1:0] KIND_ALLOC  = 2'd0;
  localparam logic [1:0] KIND_READ   = 2'd1;
  localparam logic [1:0] KIND_WINDOW = 2'd2;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  // Tag classes; codes above other act as other
  localparam logic [3:0] CLASS_VM_HEAP    = 4'd0;
  localparam logic [3:0] CLASS_WIFI       = 4'd1;
  localparam logic [3:0] CLASS_LWIP       = 4'd2;
  localparam logic [3:0] CLASS_EXT_BYTES  = 4'd3;
  localparam logic [3:0] CLASS_EXT_STRING = 4'd4;
  localparam logic [3:0] CLASS_BIGNUM     = 4'd5;
  localparam logic [3:0] CLASS_OVERHEAD   = 4'd6;
  localparam logic [3:0] CLASS_FREE       = 4'd7;
  localparam logic [3:0] CLASS_OTHER      = 4'd8;

  // Page record: flags in the low bits, byte count in units of 8 above
  localparam int FLAG_W = 7;
  localparam int CNT_W  = 9;
  localparam int REC_W  = FLAG_W + CNT_W;

  localparam logic [FLAG_W-1:0] FLAG_MANAGED  = 7'h01;
  localparam logic [FLAG_W-1:0] FLAG_VM_HEAP  = 7'h02;
  localparam logic [FLAG_W-1:0] FLAG_EXTERNAL = 7'h04;
  localparam logic [FLAG_W-1:0] FLAG_TLS      = 7'h08;
  localparam logic [FLAG_W-1:0] FLAG_BUFFERS  = 7'h10;
  localparam logic [FLAG_W-1:0] FLAG_MISC     = 7'h20;
  localparam logic [FLAG_W-1:0] FLAG_MERGE    = 7'h40;

  localparam logic [CNT_W-1:0] COUNT_MAX = 9'd511;
  localparam logic [11:0]      BYTES_MAX = 12'd4088;
  localparam logic [6:0]       PERCENT_FULL = 7'd100;

  // Byte count (12 bits) times 100 fits in 19 bits
  localparam int PROD_W = 19;
  // Read index widened to cover the largest window
  localparam int IDX_EXT_W = 11;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_CHECK,
    ST_PG_READ,
    ST_PG_WRITE,
    ST_RD_READ,
    ST_RD_DONE
  } hpum_state_t;

  typedef struct packed {
    logic in_ready;
    logic take;
    logic check;
    logic page_first;
    logic page_inc;
    logic pg_rd;
    logic rd_idx;
    logic rec_wr;
    logic clear_wr;
    logic load_out;
  } hpum_cmd_t;

  typedef struct packed {
    logic       in_valid;
    logic [1:0] in_kind;
    logic       span_ok;
    logic       is_last;
    logic       at_last_page;
    logic       out_busy;
  } hpum_sts_t;

  // Flag that a tag class sets on each covered page
  function automatic logic [FLAG_W-1:0] class_flag(input logic [3:0] cls);
    logic [FLAG_W-1:0] f;
    unique case (cls)
      CLASS_VM_HEAP:                     f = FLAG_VM_HEAP;
      CLASS_WIFI, CLASS_LWIP:            f = FLAG_BUFFERS;
      CLASS_EXT_BYTES, CLASS_EXT_STRING: f = FLAG_EXTERNAL;
      CLASS_BIGNUM:                      f = FLAG_TLS;
      CLASS_OVERHEAD, CLASS_FREE:        f = '0;
      default:                           f = FLAG_MISC;
    endcase
    return f;
  endfunction

endpackage

FILE: rtl/hpum_if.sv
// ----------------------------------------------------------------------------
// hpum_if: request and response channels of the heap page usage map
// Valid/ready channels; a word moves on a clock edge with both high.
// ----------------------------------------------------------------------------
interface hpum_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [3:0]  tag_class;
  logic [31:0] address;
  logic [31:0] span_bytes;
  logic [6:0]  page_index;

  modport source (output valid, kind, tag_class, address, span_bytes, page_index,
                  input ready);
  modport sink   (input valid, kind, tag_class, address, span_bytes, page_index,
                  output ready);
endinterface

interface hpum_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] page_flags;
  logic [6:0] fullness_percent;

  modport source (output valid, page_flags, fullness_percent, input ready);
  modport sink   (input valid, page_flags, fullness_percent, output ready);
endinterface

FILE: rtl/hpum_ctrl.sv
// ----------------------------------------------------------------------------
// hpum_ctrl: sequencer of the heap page usage map
// Dispatches each request word and steps the datapath through clear passes,
// per-page read-modify-write and record reads.
// ----------------------------------------------------------------------------
module hpum_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  hpum_pkg::hpum_sts_t sts,
  output hpum_pkg::hpum_cmd_t cmd
);

  hpum_pkg::hpum_state_t state;
  hpum_pkg::hpum_state_t state_next;

  // State register; reset starts a clear pass
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hpum_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      hpum_pkg::ST_IDLE: begin
        if (sts.in_valid) begin
          unique case (sts.in_kind)
            hpum_pkg::KIND_ALLOC:  state_next = hpum_pkg::ST_CHECK;
            hpum_pkg::KIND_READ:   state_next = hpum_pkg::ST_RD_READ;
            hpum_pkg::KIND_WINDOW: state_next = hpum_pkg::ST_CLEAR;
            default:               state_next = hpum_pkg::ST_IDLE;
          endcase
        end
      end
      hpum_pkg::ST_CLEAR: begin
        if (sts.at_last_page) state_next = hpum_pkg::ST_IDLE;
      end
      hpum_pkg::ST_CHECK: begin
        state_next = sts.span_ok ? hpum_pkg::ST_PG_READ : hpum_pkg::ST_IDLE;
      end
      hpum_pkg::ST_PG_READ: begin
        state_next = hpum_pkg::ST_PG_WRITE;
      end
      hpum_pkg::ST_PG_WRITE: begin
        state_next = sts.is_last ? hpum_pkg::ST_IDLE : hpum_pkg::ST_PG_READ;
      end
      hpum_pkg::ST_RD_READ: begin
        state_next = hpum_pkg::ST_RD_DONE;
      end
      hpum_pkg::ST_RD_DONE: begin
        if (!sts.out_busy) state_next = hpum_pkg::ST_IDLE;
      end
      default: state_next = hpum_pkg::ST_IDLE;
    endcase
  end

  // Commands to the datapath
  always_comb begin
    cmd = '0;
    unique case (state)
      hpum_pkg::ST_IDLE: begin
        cmd.in_ready = 1'b1;
        cmd.take     = sts.in_valid;
      end
      hpum_pkg::ST_CLEAR: begin
        cmd.clear_wr = 1'b1;
        cmd.page_inc = !sts.at_last_page;
      end
      hpum_pkg::ST_CHECK: begin
        cmd.check      = 1'b1;
        cmd.page_first = sts.span_ok;
      end
      hpum_pkg::ST_PG_READ: begin
        cmd.pg_rd = 1'b1;
      end
      hpum_pkg::ST_PG_WRITE: begin
        cmd.rec_wr   = 1'b1;
        cmd.page_inc = !sts.is_last;
      end
      hpum_pkg::ST_RD_READ: begin
        cmd.rd_idx = 1'b1;
      end
      hpum_pkg::ST_RD_DONE: begin
        cmd.load_out = !sts.out_busy;
      end
      default: cmd = '0;
    endcase
  end

endmodule

FILE: rtl/hpum_datapath.sv
// ----------------------------------------------------------------------------
// hpum_datapath: page record store and arithmetic of the heap page usage map
// Holds the request word, window base, page counter, record memory, span and
// overlap arithmetic, fullness percentage and the response register.
// ----------------------------------------------------------------------------
module hpum_datapath #(
  parameter int PAGE_COUNT     = 128,
  parameter int PAGE_SIZE_LOG2 = 12
) (
  input  logic                clk,
  input  logic                rst,
  hpum_in_if.sink             req,
  hpum_out_if.source          rsp,
  input  hpum_pkg::hpum_cmd_t cmd,
  output hpum_pkg::hpum_sts_t sts
);

  localparam int AW    = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
  localparam int OFF_W = $clog2(PAGE_COUNT + 1) + PAGE_SIZE_LOG2;
  localparam int OVL_W = PAGE_SIZE_LOG2 + 1;
  localparam int SUM_W = (PAGE_SIZE_LOG2 + 2 > 13) ? PAGE_SIZE_LOG2 + 2 : 13;
  localparam logic [32:0]      WIN_BYTES  = 33'(PAGE_COUNT) << PAGE_SIZE_LOG2;
  localparam logic [31:0]      PAGE_MASK  = ~((32'd1 << PAGE_SIZE_LOG2) - 32'd1);
  localparam logic [OFF_W-1:0] PAGE_BYTES = OFF_W'(1) << PAGE_SIZE_LOG2;
  localparam logic [AW-1:0]    LAST_PAGE  = AW'(PAGE_COUNT - 1);

  // Request word
  logic [3:0]  cls;
  logic [31:0] addr;
  logic [31:0] span;
  logic [32:0] end_addr;
  logic [AW-1:0] idx_addr;
  logic        idx_ok;
  logic [hpum_pkg::IDX_EXT_W-1:0] idx_ext;

  // Window
  logic [31:0] base;
  logic [31:0] base_new;
  logic [32:0] win_end;

  // Span walk
  logic [OFF_W-1:0] off_s;
  logic [OFF_W-1:0] off_e;
  logic [32:0]      off_s_full;
  logic [32:0]      off_e_full;
  logic [AW-1:0]    page;
  logic [OVL_W-1:0] ovl;
  logic             is_last;
  logic             span_ok;

  // Segment of the span inside the current page
  logic [OFF_W-1:0] pg_s;
  logic [OFF_W-1:0] pg_e;
  logic [OFF_W-1:0] seg_s;
  logic [OFF_W-1:0] seg_e;
  logic [OFF_W-1:0] seg_len;
  logic [OFF_W-1:0] last_off;

  // Record memory
  logic [hpum_pkg::REC_W-1:0] mem [PAGE_COUNT];
  logic [hpum_pkg::REC_W-1:0] rdata;
  logic [hpum_pkg::REC_W-1:0] new_rec;
  logic [AW-1:0]              rd_addr;

  // Record update
  logic [hpum_pkg::CNT_W-1:0]  old_cnt;
  logic [hpum_pkg::CNT_W-1:0]  new_cnt;
  logic [hpum_pkg::FLAG_W-1:0] new_flags;
  logic [SUM_W-1:0]            sum;
  logic [SUM_W-1:0]            sat_bytes;

  // Fullness
  logic [hpum_pkg::PROD_W-1:0] prod;
  logic [hpum_pkg::PROD_W-1:0] scaled;
  logic [6:0]                  pct;

  // Response register
  logic       out_valid;
  logic [6:0] out_flags;
  logic [6:0] out_pct;

  // Hold the request word
  assign idx_ext = hpum_pkg::IDX_EXT_W'(req.page_index);

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      cls      <= req.tag_class;
      addr     <= req.address;
      span     <= req.span_bytes;
      end_addr <= {1'b0, req.address} + {1'b0, req.span_bytes};
      idx_addr <= idx_ext[AW-1:0];
      idx_ok   <= idx_ext < hpum_pkg::IDX_EXT_W'(PAGE_COUNT);
    end
  end

  // Load a new window base, page aligned
  assign base_new = req.address & PAGE_MASK;

  always_ff @(posedge clk) begin
    if (rst) begin
      base    <= '0;
      win_end <= WIN_BYTES;
    end else if (cmd.take && req.kind == hpum_pkg::KIND_WINDOW) begin
      base    <= base_new;
      win_end <= {1'b0, base_new} + WIN_BYTES;
    end
  end

  // Check the span against the window
  assign span_ok    = (span != '0) && (addr >= base) && (end_addr <= win_end);
  assign off_s_full = {1'b0, addr} - {1'b0, base};
  assign off_e_full = end_addr - {1'b0, base};

  always_ff @(posedge clk) begin
    if (cmd.check) begin
      off_s <= off_s_full[OFF_W-1:0];
      off_e <= off_e_full[OFF_W-1:0];
    end
  end

  // Page counter
  always_ff @(posedge clk) begin
    if (rst) begin
      page <= '0;
    end else if (cmd.take) begin
      page <= '0;
    end else if (cmd.page_first) begin
      page <= off_s_full[PAGE_SIZE_LOG2+AW-1:PAGE_SIZE_LOG2];
    end else if (cmd.page_inc) begin
      page <= page + AW'(1);
    end
  end

  // Overlap of the span with the current page
  assign pg_s     = OFF_W'(page) << PAGE_SIZE_LOG2;
  assign pg_e     = pg_s + PAGE_BYTES;
  assign seg_s    = (off_s > pg_s) ? off_s : pg_s;
  assign seg_e    = (off_e < pg_e) ? off_e : pg_e;
  assign seg_len  = seg_e - seg_s;
  assign last_off = off_e - OFF_W'(1);

  always_ff @(posedge clk) begin
    if (cmd.pg_rd) begin
      ovl     <= seg_len[OVL_W-1:0];
      is_last <= page == last_off[PAGE_SIZE_LOG2+AW-1:PAGE_SIZE_LOG2];
    end
  end

  // Merge the overlap into the stored record
  assign old_cnt   = rdata[hpum_pkg::REC_W-1:hpum_pkg::FLAG_W];
  assign sum       = SUM_W'({old_cnt, 3'b000}) + SUM_W'(ovl);
  assign sat_bytes = (sum > SUM_W'(hpum_pkg::BYTES_MAX)) ? SUM_W'(hpum_pkg::BYTES_MAX) : sum;
  assign new_cnt   = (cls == hpum_pkg::CLASS_FREE) ? old_cnt : sat_bytes[11:3];
  assign new_flags = rdata[hpum_pkg::FLAG_W-1:0] | hpum_pkg::FLAG_MANAGED
                   | hpum_pkg::class_flag(cls)
                   | (is_last ? '0 : hpum_pkg::FLAG_MERGE);
  assign new_rec   = {new_cnt, new_flags};

  // Record memory: one write port, one registered read port
  assign rd_addr = cmd.rd_idx ? idx_addr : page;

  always_ff @(posedge clk) begin
    if (cmd.rec_wr || cmd.clear_wr) begin
      mem[page] <= cmd.clear_wr ? '0 : new_rec;
    end
    if (cmd.pg_rd || cmd.rd_idx) begin
      rdata <= mem[rd_addr];
    end
  end

  // Fullness percentage of the record just read
  assign prod   = hpum_pkg::PROD_W'({old_cnt, 3'b000})
                * hpum_pkg::PROD_W'(hpum_pkg::PERCENT_FULL);
  assign scaled = prod >> PAGE_SIZE_LOG2;
  assign pct    = (old_cnt == hpum_pkg::COUNT_MAX
                   || scaled > hpum_pkg::PROD_W'(hpum_pkg::PERCENT_FULL))
                ? hpum_pkg::PERCENT_FULL : scaled[6:0];

  // Response register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_flags <= idx_ok ? rdata[hpum_pkg::FLAG_W-1:0] : '0;
      out_pct   <= idx_ok ? pct : '0;
    end
  end

  assign rsp.valid            = out_valid;
  assign rsp.page_flags       = out_flags;
  assign rsp.fullness_percent = out_pct;
  assign req.ready            = cmd.in_ready;

  // Status to the controller
  assign sts.in_valid     = req.valid;
  assign sts.in_kind      = req.kind;
  assign sts.span_ok      = span_ok;
  assign sts.is_last      = is_last;
  assign sts.at_last_page = page == LAST_PAGE;
  assign sts.out_busy     = out_valid && !rsp.ready;

endmodule

FILE: rtl/heap_page_usage_map.sv
// ----------------------------------------------------------------------------
// heap_page_usage_map: usage records for a window of heap pages
// Top level joining the sequencer and the record datapath.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one request word per handshake: register an allocation
//   (kind 0), read a page record (kind 1) or start a new window (kind 2).
//   rsp carries one word (page flags, fullness percent) per read request.
//   Sequence from the edge that takes a word until req.ready is high again:
//     read:       the record is read, then loaded into the response register,
//                 a step that waits while rsp holds an earlier result.
//     allocation: a window check, then one read and one write of the record
//                 memory per covered page; only the check if it is ignored.
//     window:     all PAGE_COUNT records cleared, one record cleared per cycle.
//   After reset the block clears all PAGE_COUNT records, one per cycle, with
//   req.ready low, and the window base is zero.
//   The response register lets the next request be taken while a read
//   result waits; a later read waits for rsp to drain before it completes.
// ----------------------------------------------------------------------------
module heap_page_usage_map #(
  parameter int PAGE_COUNT     = 128,
  parameter int PAGE_SIZE_LOG2 = 12
) (
  input  logic       clk,
  input  logic       rst,
  hpum_in_if.sink    req,
  hpum_out_if.source rsp
);

  hpum_pkg::hpum_cmd_t cmd;
  hpum_pkg::hpum_sts_t sts;

  hpum_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .cmd (cmd)
  );

  hpum_datapath #(
    .PAGE_COUNT     (PAGE_COUNT),
    .PAGE_SIZE_LOG2 (PAGE_SIZE_LOG2)
  ) u_datapath (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp),
    .cmd (cmd),
    .sts (sts)
  );

  // No new word is taken during a clear pass
  a_clear_blocks_input: assert property (@(posedge clk) disable iff (rst)
    cmd.clear_wr |-> !req.ready)
    else $error("request taken during clear pass");

  // A result is never loaded over one still waiting
  a_no_result_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> !sts.out_busy)
    else $error("result loaded while response stalled");

  // Record update and clear never share the write port
  a_single_write: assert property (@(posedge clk) disable iff (rst)
    !(cmd.rec_wr && cmd.clear_wr))
    else $error("record write and clear in one cycle");

  // A read request keeps the input closed on the next cycle
  a_read_busy: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready && req.kind == hpum_pkg::KIND_READ) |=> !req.ready)
    else $error("input open while a read is in progress");

endmodule

FILE: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the heap page usage map
// Drives request words (allocations, page reads, window starts) under random
// gaps and back-pressure. A page record model in the bench predicts every
// read response, and each response is checked in order against it.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int  PAGE_COUNT  = 128;
  localparam int  PAGE_LOG2   = 12;
  localparam int  PAGE_BYTES  = 1 << PAGE_LOG2;
  localparam int  CYCLE_LIMIT = 1000000;
  localparam int  SETTLE      = 300;

  typedef struct {
    logic [6:0] flags;
    logic [6:0] percent;
  } page_report_t;

  logic clk = 1'b0;
  logic rst;

  hpum_in_if  req_if ();
  hpum_out_if rsp_if ();

  heap_page_usage_map #(
    .PAGE_COUNT    (PAGE_COUNT),
    .PAGE_SIZE_LOG2(PAGE_LOG2)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .req(req_if),
    .rsp(rsp_if)
  );

  // Page record model: flags in bits 6..0, byte count / 8 in bits 15..7
  logic [15:0]  page_rec [PAGE_COUNT];
  logic [31:0]  win_base;
  page_report_t pending_reports [$];

  int  error_count = 0;
  int  cycle_count = 0;
  int  rsp_hold    = 0;
  int  hot_page    = 0;
  bit  tx_gaps     = 1'b1;
  bit  rx_gaps     = 1'b1;

  // Clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic logic [6:0] flag_of_class(input logic [3:0] cls);
    case (cls)
      hpum_pkg::CLASS_VM_HEAP:             return hpum_pkg::FLAG_VM_HEAP;
      hpum_pkg::CLASS_WIFI,
      hpum_pkg::CLASS_LWIP:                return hpum_pkg::FLAG_BUFFERS;
      hpum_pkg::CLASS_EXT_BYTES,
      hpum_pkg::CLASS_EXT_STRING:          return hpum_pkg::FLAG_EXTERNAL;
      hpum_pkg::CLASS_BIGNUM:              return hpum_pkg::FLAG_TLS;
      hpum_pkg::CLASS_OVERHEAD,
      hpum_pkg::CLASS_FREE:                return '0;
      default:                             return hpum_pkg::FLAG_MISC;
    endcase
  endfunction

  // Mark every page that an allocation covers; drop spans outside the window
  function automatic void track_alloc(input logic [3:0] cls, input logic [31:0] addr,
                                      input logic [31:0] span);
    logic [63:0] a, stop, lo, hi, first, last, ps, pe, s, e, bytes;
    logic [6:0]  flags;
    int          p;
    a    = 64'(addr);
    stop = a + 64'(span);
    lo   = 64'(win_base);
    hi   = lo + (64'(PAGE_COUNT) << PAGE_LOG2);
    if (span == 0 || a < lo || stop > hi) return;
    first = (a - lo) >> PAGE_LOG2;
    last  = (stop - 64'd1 - lo) >> PAGE_LOG2;
    for (p = int'(first); p <= int'(last); p++) begin
      flags = page_rec[p][6:0] | hpum_pkg::FLAG_MANAGED | flag_of_class(cls);
      bytes = 64'(page_rec[p][15:7]) << 3;
      if (p != int'(last)) flags |= hpum_pkg::FLAG_MERGE;
      if (cls != hpum_pkg::CLASS_FREE) begin
        ps = lo + (64'(p) << PAGE_LOG2);
        pe = ps + 64'(PAGE_BYTES);
        s  = (a > ps) ? a : ps;
        e  = (stop < pe) ? stop : pe;
        bytes += e - s;
        if (bytes > 64'(hpum_pkg::BYTES_MAX)) bytes = 64'(hpum_pkg::BYTES_MAX);
      end
      page_rec[p] = {bytes[11:3], flags};
    end
  endfunction

  // Flags and fullness of one page as a read returns them
  function automatic page_report_t page_report(input logic [6:0] idx);
    page_report_t r;
    logic [15:0]  rec;
    logic [63:0]  bytes, pct;
    rec   = page_rec[idx];
    bytes = 64'(rec[15:7]) << 3;
    if (bytes >= 64'(hpum_pkg::BYTES_MAX)) begin
      pct = 64'(hpum_pkg::PERCENT_FULL);
    end else begin
      pct = (bytes * 64'(hpum_pkg::PERCENT_FULL)) >> PAGE_LOG2;
      if (pct > 64'(hpum_pkg::PERCENT_FULL)) pct = 64'(hpum_pkg::PERCENT_FULL);
    end
    r.flags   = rec[6:0];
    r.percent = pct[6:0];
    return r;
  endfunction

  function automatic void clear_records(input logic [31:0] base);
    foreach (page_rec[i]) page_rec[i] = '0;
    win_base = (base >> PAGE_LOG2) << PAGE_LOG2;
  endfunction

  function automatic void predict_word(input logic [1:0] kind, input logic [3:0] cls,
                                       input logic [31:0] addr, input logic [31:0] span,
                                       input logic [6:0] idx);
    case (kind)
      hpum_pkg::KIND_ALLOC:  track_alloc(cls, addr, span);
      hpum_pkg::KIND_READ:   pending_reports.push_back(page_report(idx));
      hpum_pkg::KIND_WINDOW: clear_records(addr);
      default: ;
    endcase
  endfunction

  function automatic void flag_error(input string what, input page_report_t want,
                                     input page_report_t got);
    error_count++;
    if (error_count <= 10)
      $display("ERROR %s: expected flags %h pct %0d, got flags %h pct %0d",
               what, want.flags, want.percent, got.flags, got.percent);
  endfunction

  // Check each response word against the oldest prediction
  always @(posedge clk) begin
    page_report_t want, got;
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      got.flags   = rsp_if.page_flags;
      got.percent = rsp_if.fullness_percent;
      if (pending_reports.size() == 0) begin
        want = '{flags: '0, percent: '0};
        flag_error("response with none pending", want, got);
      end else begin
        want = pending_reports.pop_front();
        if (got.flags !== want.flags || got.percent !== want.percent)
          flag_error("page report mismatch", want, got);
      end
    end
  end

  // Response ready: random gaps, or hold off for a counted stretch
  always @(negedge clk) begin
    if (rst) begin
      rsp_if.ready <= 1'b0;
    end else if (rsp_hold > 0) begin
      rsp_if.ready <= 1'b0;
      rsp_hold--;
    end else begin
      rsp_if.ready <= !(rx_gaps && $urandom_range(99) < 18);
    end
  end

  // Offer one word, hold it until taken, then record its effect
  task automatic send_word(input logic [1:0] kind, input logic [3:0] cls,
                           input logic [31:0] addr, input logic [31:0] span,
                           input logic [6:0] idx);
    @(negedge clk);
    while (tx_gaps && $urandom_range(99) < 18) begin
      req_if.valid <= 1'b0;
      @(negedge clk);
    end
    req_if.valid      <= 1'b1;
    req_if.kind       <= kind;
    req_if.tag_class  <= cls;
    req_if.address    <= addr;
    req_if.span_bytes <= span;
    req_if.page_index <= idx;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    predict_word(kind, cls, addr, span, idx);
  endtask

  task automatic alloc(input logic [3:0] cls, input logic [31:0] addr, input logic [31:0] span);
    send_word(hpum_pkg::KIND_ALLOC, cls, addr, span, 7'($urandom));
  endtask

  task automatic read_page(input logic [6:0] idx);
    send_word(hpum_pkg::KIND_READ, 4'($urandom), $urandom, $urandom, idx);
  endtask

  task automatic new_window(input logic [31:0] addr);
    send_word(hpum_pkg::KIND_WINDOW, 4'($urandom), addr, $urandom, 7'($urandom));
  endtask

  // Drop valid and wait until every read response has come back
  task automatic wait_drained();
    @(negedge clk);
    req_if.valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
  endtask

  task automatic test_after_reset();
    read_page(7'd0);
    read_page(7'd127);
  endtask

  task automatic test_record_classes();
    logic [31:0] b;
    // Base is rounded down to a page
    new_window(32'h2000_0ABC);
    b = 32'h2000_0000;
    // Partial unit of eight bytes
    alloc(hpum_pkg::CLASS_VM_HEAP, b, 32'd13);
    // Span crossing into the next page sets merge on the first
    alloc(hpum_pkg::CLASS_WIFI, b + 32'h0FF0, 32'h20);
    // Whole page saturates the count
    alloc(hpum_pkg::CLASS_EXT_BYTES, b + 32'h2000, 32'h1000);
    alloc(hpum_pkg::CLASS_BIGNUM, b + 32'h3000, 32'h800);
    alloc(hpum_pkg::CLASS_OVERHEAD, b + 32'h3800, 32'h10);
    // Free class sets only the managed flag
    alloc(hpum_pkg::CLASS_FREE, b + 32'h4000, 32'h100);
    alloc(hpum_pkg::CLASS_OTHER, b + 32'h5000, 32'd64);
    // Highest class code acts as other
    alloc(4'd15, b + 32'h5000, 32'd64);
    // Ignored: empty span, start below base, end past window
    alloc(hpum_pkg::CLASS_VM_HEAP, b + 32'h3000, 32'd0);
    alloc(hpum_pkg::CLASS_VM_HEAP, b - 32'd1, 32'd4);
    alloc(hpum_pkg::CLASS_LWIP, b + 32'(127 * PAGE_BYTES), 32'(PAGE_BYTES + 1));
    // Last page, ending exactly at the window end
    alloc(hpum_pkg::CLASS_EXT_STRING, b + 32'(127 * PAGE_BYTES), 32'(PAGE_BYTES));
    // Unused kind does nothing
    send_word(hpum_pkg::KIND_UNUSED, 4'hF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 7'h7F);
    for (int i = 0; i < 6; i++) read_page(7'(i));
    read_page(7'd127);
  endtask

  task automatic test_window_extremes();
    // Window at the top of the address space; sums must not wrap
    new_window(32'hFFFF_FFFF);
    alloc(4'hF, 32'hFFFF_F000, 32'h0000_1000);
    alloc(hpum_pkg::CLASS_VM_HEAP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    read_page(7'd0);
    // Span covering every page of the window
    new_window(32'h0);
    alloc(hpum_pkg::CLASS_WIFI, 32'h0, 32'(PAGE_COUNT * PAGE_BYTES));
    read_page(7'd64);
    read_page(7'd127);
  endtask

  task automatic test_random_traffic(input int n);
    int          useful, sel, off, r;
    logic [31:0] span;
    useful = 0;
    while (useful < n) begin
      // Run a stretch with no gaps on either side
      if (useful == n / 3) begin
        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
      end else if (useful == n / 3 + 100) begin
        tx_gaps = 1'b1;
        rx_gaps = 1'b1;
      end
      sel = $urandom_range(99);
      if (sel < 3) begin
        new_window($urandom_range(1) ? $urandom : $urandom_range(0, 32'h00FF_FFFF));
        useful++;
      end else if (sel < 5) begin
        send_word(hpum_pkg::KIND_UNUSED, 4'($urandom), $urandom, $urandom, 7'($urandom));
      end else if (sel < 45) begin
        if ($urandom_range(1))
          read_page(7'((hot_page + $urandom_range(0, 3)) % PAGE_COUNT));
        else
          read_page(7'($urandom));
        useful++;
      end else if (sel < 52) begin
        alloc(4'($urandom), $urandom, $urandom);
      end else begin
        off = $urandom_range(0, PAGE_COUNT * PAGE_BYTES - 1);
        r   = $urandom_range(99);
        if (r < 60)      span = $urandom_range(1, 512);
        else if (r < 90) span = $urandom_range(1, 3 * PAGE_BYTES);
        else if (r < 99) span = $urandom_range(1, 16 * PAGE_BYTES);
        else             span = $urandom_range(1, PAGE_COUNT * PAGE_BYTES);
        hot_page = off >> PAGE_LOG2;
        alloc(4'($urandom_range(0, 15)), win_base + 32'(off), span);
        useful++;
      end
    end
  endtask

  // Stall the response side long enough that the request side backs up
  task automatic test_response_stall();
    rsp_hold = 400;
    for (int i = 0; i < 24; i++) begin
      if (i % 3 == 0)
        alloc(4'($urandom_range(0, 8)), win_base + 32'($urandom_range(0, 8 * PAGE_BYTES)),
              $urandom_range(1, 256));
      else
        read_page(7'($urandom_range(0, 9)));
    end
    wait_drained();
  endtask

  // Pause the sender until every response is back, then resume
  task automatic test_drain_pause();
    for (int i = 0; i < 8; i++) read_page(7'($urandom));
    wait_drained();
    for (int i = 0; i < 8; i++) begin
      alloc(hpum_pkg::CLASS_VM_HEAP, win_base + 32'(i * 100), 32'd100);
      read_page(7'd0);
    end
  endtask

  initial begin
    req_if.valid      = 1'b0;
    req_if.kind       = hpum_pkg::KIND_ALLOC;
    req_if.tag_class  = hpum_pkg::CLASS_VM_HEAP;
    req_if.address    = '0;
    req_if.span_bytes = '0;
    req_if.page_index = '0;
    rst               = 1'b1;
    clear_records(32'h0);

    // Hold reset, then release it at a falling clock edge
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_after_reset();
    test_record_classes();
    test_window_extremes();
    test_random_traffic(400);
    test_response_stall();
    test_drain_pause();

    // Drain and let any trailing allocation finish
    wait_drained();
    repeat (SETTLE) @(posedge clk);
    if (pending_reports.size() != 0) begin
      error_count++;
      $display("ERROR %0d page reports never arrived", pending_reports.size());
    end
    if (error_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
